// File: rtl/cnco_pkg.sv
// Shared types, constants and the sine table generator for the complex NCO.
// Used by every module of the block; depends on nothing.
`default_nettype none
package cnco_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IQ_W       = 16;
  localparam int CNT_W      = 16;
  localparam int STEP_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd3;

  localparam logic [STEP_W-1:0] PHASE_STEP_RST   = 32'd0;
  localparam logic [STEP_W-1:0] PHASE_OFFSET_RST = 32'd0;
  localparam logic [IQ_W-1:0]   AMPLITUDE_RST    = 16'h7FFF;
  localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = 16'd1024;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] SERIES_DIV [7] = '{64'd210, 64'd156, 64'd110, 64'd72,
                                             64'd42, 64'd20, 64'd6};

  typedef struct packed {
    logic accept;
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } cnco_pipe_t;

  typedef struct packed {
    logic [CNT_W-1:0] sample_index;
    logic             last;
  } cnco_meta_t;

  // Quarter-wave sine magnitude for table entry k, evaluated at elaboration.
  function automatic logic [63:0] sine_entry(input int k, input int addr_bits,
                                             input int sample_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] e;
    x  = (PI_HALF_Q30 * (64'(2 * k + 1))) >> (addr_bits + 1);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int i = 0; i < 7; i++) begin
      t = Q30_ONE - (((x2 * t) >> 30) / SERIES_DIV[i]);
    end
    s = (x * t) >> 30;
    m = (64'd1 << (sample_bits - 1)) - 64'd1;
    e = (s * m + (Q30_ONE >> 1)) >> 30;
    if (e > m) begin
      e = m;
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cnco_seq.sv
// Phase accumulator and sample counter, plus the first pipeline register.
// Depends on cnco_pkg.
`default_nettype none
module cnco_seq
  import cnco_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cnco_pipe_t            pipe,
  input  wire logic                  start_req,
  input  wire logic [STEP_W-1:0]     phase_step,
  input  wire logic [STEP_W-1:0]     phase_offset,
  input  wire logic [CNT_W-1:0]      sample_count,
  output logic      [PHASE_BITS-1:0] phase_r,
  output cnco_meta_t                 meta_r
);

  logic [PHASE_BITS-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [PHASE_BITS-1:0] offset_p;
  logic [PHASE_BITS-1:0] step_p;
  logic [PHASE_BITS+STEP_W-1:0] offset_ext;
  logic [PHASE_BITS+STEP_W-1:0] step_ext;
  logic [PHASE_BITS-1:0] cur_phase;
  logic [CNT_W-1:0]      cur_cnt;
  logic [CNT_W:0]        cnt_inc;
  logic                  is_last;

  always_comb begin
    offset_ext = {{PHASE_BITS{1'b0}}, phase_offset};
    step_ext   = {{PHASE_BITS{1'b0}}, phase_step};
    offset_p   = offset_ext[PHASE_BITS-1:0];
    step_p     = step_ext[PHASE_BITS-1:0];
    cur_phase  = start_req ? offset_p : acc_r;
    cur_cnt    = start_req ? '0 : cnt_r;
    cnt_inc    = {1'b0, cur_cnt} + (CNT_W+1)'(1);
    is_last    = cnt_inc >= {1'b0, sample_count};
    if (is_last) begin
      acc_nxt = offset_p;
      cnt_nxt = '0;
    end else begin
      acc_nxt = cur_phase + step_p;
      cnt_nxt = cnt_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (pipe.accept) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.en1) begin
      phase_r             <= cur_phase;
      meta_r.sample_index <= cur_cnt;
      meta_r.last         <= is_last;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cnco_rom.sv
// Quarter-wave sine ROM with two registered read ports for sine and cosine.
// Depends on cnco_pkg for the table generator.
`default_nettype none
module cnco_rom
  import cnco_pkg::*;
#(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire cnco_pipe_t             pipe,
  input  wire logic [PHASE_BITS-1:0]  phase,
  output logic      [SAMPLE_BITS-2:0] sin_mag_r,
  output logic      [SAMPLE_BITS-2:0] cos_mag_r,
  output logic                        sin_neg_r,
  output logic                        cos_neg_r
);

  localparam int ROM_SIZE = 1 << TABLE_ADDR_BITS;
  localparam int MAG_W    = SAMPLE_BITS - 1;

  typedef logic [MAG_W-1:0] rom_t [ROM_SIZE];

  function automatic rom_t build_rom();
    rom_t tbl;
    for (int k = 0; k < ROM_SIZE; k++) begin
      tbl[k] = MAG_W'(sine_entry(k, TABLE_ADDR_BITS, SAMPLE_BITS));
    end
    return tbl;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [1:0]                 sin_q;
  logic [1:0]                 cos_q;
  logic [TABLE_ADDR_BITS-1:0] k;
  logic [TABLE_ADDR_BITS-1:0] sin_addr;
  logic [TABLE_ADDR_BITS-1:0] cos_addr;

  always_comb begin
    sin_q    = phase[PHASE_BITS-1 -: 2];
    cos_q    = sin_q + 2'd1;
    k        = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    sin_addr = sin_q[0] ? ~k : k;
    cos_addr = cos_q[0] ? ~k : k;
  end

  always_ff @(posedge clk) begin
    if (pipe.en2) begin
      sin_mag_r <= ROM[sin_addr];
      cos_mag_r <= ROM[cos_addr];
      sin_neg_r <= sin_q[1];
      cos_neg_r <= cos_q[1];
    end
  end

endmodule
`default_nettype wire

// File: rtl/cnco_scale.sv
// Amplitude multiply, round-half-up to Q1.15 and saturation for one rail.
// Depends on cnco_pkg.
`default_nettype none
module cnco_scale
  import cnco_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire cnco_pipe_t              pipe,
  input  wire logic signed [IQ_W-1:0]  amplitude,
  input  wire logic [SAMPLE_BITS-2:0]  mag,
  input  wire logic                    neg,
  output logic signed      [IQ_W-1:0]  iq_r
);

  localparam int PROD_W = IQ_W + SAMPLE_BITS;
  localparam logic signed [PROD_W:0] SAT_HI = (PROD_W+1)'(32767);
  localparam logic signed [PROD_W:0] SAT_LO = -(PROD_W+1)'(32768);
  localparam logic signed [PROD_W:0] RND    = (PROD_W+1)'(1) <<< (SAMPLE_BITS - 2);

  logic signed [SAMPLE_BITS-1:0] val;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [PROD_W:0]        rounded;
  logic signed [PROD_W:0]        shifted;
  logic signed [IQ_W-1:0]        iq_nxt;

  always_comb begin
    val = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (pipe.en3) begin
      prod_r <= PROD_W'(amplitude * val);
    end
  end

  always_comb begin
    rounded = $signed({prod_r[PROD_W-1], prod_r}) + RND;
    shifted = rounded >>> (SAMPLE_BITS - 1);
    if (shifted > SAT_HI) begin
      iq_nxt = IQ_W'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      iq_nxt = IQ_W'(SAT_LO);
    end else begin
      iq_nxt = shifted[IQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.en4) begin
      iq_r <= iq_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/complex_sinusoid_nco.sv
// Top level of the complex NCO: configuration registers, pipeline control and
// the phase, ROM and scaling stages. Depends on cnco_pkg and all cnco_ modules.
//
// One complex sample leaves for every input transfer accepted, at a sustained
// rate of one per clock while out_ready is high; each sample passes the
// phase, ROM, product and output registers before it is presented. The rate is
// set by the phase accumulator and sample counter update, and the two-port sine
// ROM is read once per sample. Each stage holds its item while the output is
// stalled, so bubbles are absorbed and input transfers continue until the
// pipeline is full. Configuration is taken at any clock edge with cfg_we high
// and should be written only while the block is idle.
`default_nettype none
module complex_sinusoid_nco
  import cnco_pkg::*;
#(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_start_req,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [IQ_W-1:0]      out_in_phase,
  output logic signed [IQ_W-1:0]      out_quadrature,
  output logic [CNT_W-1:0]            out_sample_index,
  output logic                        out_last
);

  logic [STEP_W-1:0]      phase_step_r;
  logic [STEP_W-1:0]      phase_offset_r;
  logic signed [IQ_W-1:0] amplitude_r;
  logic [CNT_W-1:0]       sample_count_r;

  logic v1_r, v2_r, v3_r, v4_r;
  cnco_pipe_t pipe;

  logic [PHASE_BITS-1:0]  phase1;
  cnco_meta_t             meta1, meta2_r, meta3_r, meta4_r;
  logic [SAMPLE_BITS-2:0] sin_mag, cos_mag;
  logic                   sin_neg, cos_neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= PHASE_STEP_RST;
      phase_offset_r <= PHASE_OFFSET_RST;
      amplitude_r    <= AMPLITUDE_RST;
      sample_count_r <= SAMPLE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_STEP:   phase_step_r   <= cfg_data;
        CFG_PHASE_OFFSET: phase_offset_r <= cfg_data;
        CFG_AMPLITUDE:    amplitude_r    <= cfg_data[IQ_W-1:0];
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pipe.en4    = !v4_r || out_ready;
    pipe.en3    = !v3_r || pipe.en4;
    pipe.en2    = !v2_r || pipe.en3;
    pipe.en1    = !v1_r || pipe.en2;
    pipe.accept = in_valid && pipe.en1;
    in_ready    = pipe.en1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (pipe.en1) v1_r <= in_valid;
      if (pipe.en2) v2_r <= v1_r;
      if (pipe.en3) v3_r <= v2_r;
      if (pipe.en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.en2) meta2_r <= meta1;
    if (pipe.en3) meta3_r <= meta2_r;
    if (pipe.en4) meta4_r <= meta3_r;
  end

  cnco_seq #(
    .PHASE_BITS(PHASE_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .pipe         (pipe),
    .start_req    (in_start_req),
    .phase_step   (phase_step_r),
    .phase_offset (phase_offset_r),
    .sample_count (sample_count_r),
    .phase_r      (phase1),
    .meta_r       (meta1)
  );

  cnco_rom #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_rom (
    .clk       (clk),
    .pipe      (pipe),
    .phase     (phase1),
    .sin_mag_r (sin_mag),
    .cos_mag_r (cos_mag),
    .sin_neg_r (sin_neg),
    .cos_neg_r (cos_neg)
  );

  cnco_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale_i (
    .clk       (clk),
    .pipe      (pipe),
    .amplitude (amplitude_r),
    .mag       (cos_mag),
    .neg       (cos_neg),
    .iq_r      (out_in_phase)
  );

  cnco_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale_q (
    .clk       (clk),
    .pipe      (pipe),
    .amplitude (amplitude_r),
    .mag       (sin_mag),
    .neg       (sin_neg),
    .iq_r      (out_quadrature)
  );

  assign out_valid        = v4_r;
  assign out_sample_index = meta4_r.sample_index;
  assign out_last         = meta4_r.last;

endmodule
`default_nettype wire
